FILE: rtl/core/hpbc_pkg.sv
package hpbc_pkg;

    // field widths
    localparam int COORD_W     = 32;
    localparam int NORM_W      = 16;
    localparam int CNT_W       = 3;
    localparam int NUM_CORNERS = 4;
    localparam int NORM_FRAC   = 14;
    localparam int ROUND_HALF  = 1 << (NORM_FRAC - 1);

    // datapath widths
    localparam int PROD_W = NORM_W + COORD_W;
    localparam int DIST_W = PROD_W + 2;
    localparam int DC_W   = DIST_W - NORM_FRAC;
    localparam int CORR_W = NORM_W + DC_W;
    localparam int PROJ_W = CORR_W - NORM_FRAC + 2;
    localparam int SUM_W  = PROJ_W + 2;
    localparam int T_W    = SUM_W + 1;

    // divide by three: biased operand, split at U_SPLIT bits, reciprocal for the low part
    localparam longint DIV3_BIAS   = 3 * ((longint'(1) << (COORD_W - 1)) + 1);
    localparam int     U_W         = 34;
    localparam int     U_SPLIT     = 18;
    localparam int     UH_W        = U_W - U_SPLIT;
    localparam int     V_W         = U_SPLIT + 1;
    localparam int     HI_MUL      = ((1 << U_SPLIT) - 1) / 3;
    localparam int     HI_MUL_W    = 17;
    localparam int     M1_W        = UH_W + HI_MUL_W;
    localparam int     RECIP_SHIFT = V_W + 1;
    localparam int     LO_MUL      = ((1 << RECIP_SHIFT) + 2) / 3;
    localparam int     M2P_W       = V_W + RECIP_SHIFT;
    localparam int     M2_W        = M2P_W - RECIP_SHIFT;

    // configuration port
    localparam int ADDR_W = 4;
    localparam int DATA_W = 32;
    localparam logic [1:0] REG_NORMAL_X = 2'd0;
    localparam logic [1:0] REG_NORMAL_Y = 2'd1;
    localparam logic [1:0] REG_OFFSET   = 2'd2;

    localparam logic signed [NORM_W-1:0] NORMAL_ONE = 16'sd16384;

    typedef struct packed {
        logic signed [COORD_W-1:0] corner0_x;
        logic signed [COORD_W-1:0] corner0_y;
        logic signed [COORD_W-1:0] corner1_x;
        logic signed [COORD_W-1:0] corner1_y;
        logic signed [COORD_W-1:0] corner2_x;
        logic signed [COORD_W-1:0] corner2_y;
        logic signed [COORD_W-1:0] corner3_x;
        logic signed [COORD_W-1:0] corner3_y;
    } in_t;

    typedef struct packed {
        logic                      hit;
        logic signed [COORD_W-1:0] contact_x;
        logic signed [COORD_W-1:0] contact_y;
        logic signed [NORM_W-1:0]  contact_normal_x;
        logic signed [NORM_W-1:0]  contact_normal_y;
        logic [CNT_W-1:0]          inside_count;
    } out_t;

    // stage advance for the corner lanes
    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
        logic s4;
    } lane_en_t;

    // stage advance for the mean unit
    typedef struct packed {
        logic s6;
        logic s7;
    } mean_en_t;

    // saturate to the signed coordinate range
    function automatic logic signed [COORD_W-1:0] sat32(input logic signed [T_W-1:0] v);
        logic [T_W-COORD_W:0] top;
        logic signed [COORD_W-1:0] r;
        top = v[T_W-1:COORD_W-1];
        if (top == '0 || top == '1)
        begin
            r = v[COORD_W-1:0];
        end
        else if (v[T_W-1])
        begin
            r = {1'b1, {(COORD_W-1){1'b0}}};
        end
        else
        begin
            r = {1'b0, {(COORD_W-1){1'b1}}};
        end
        return r;
    endfunction

endpackage

FILE: rtl/core/hpbc_corner.sv
module hpbc_corner (
    input  logic                                    clk,
    input  hpbc_pkg::lane_en_t                      en,
    input  logic signed [hpbc_pkg::COORD_W-1:0]     px,
    input  logic signed [hpbc_pkg::COORD_W-1:0]     py,
    input  logic signed [hpbc_pkg::NORM_W-1:0]      nx,
    input  logic signed [hpbc_pkg::NORM_W-1:0]      ny,
    input  logic signed [hpbc_pkg::COORD_W-1:0]     offset,
    output logic signed [hpbc_pkg::PROJ_W-1:0]      proj_x,
    output logic signed [hpbc_pkg::PROJ_W-1:0]      proj_y,
    output logic                                    corner_in
);

    localparam int CW = hpbc_pkg::COORD_W;
    localparam int PW = hpbc_pkg::PROD_W;
    localparam int DW = hpbc_pkg::DIST_W;
    localparam int KW = hpbc_pkg::DC_W;
    localparam int RW = hpbc_pkg::CORR_W;
    localparam int JW = hpbc_pkg::PROJ_W;
    localparam int FR = hpbc_pkg::NORM_FRAC;

    logic signed [PW-1:0] prod_x_reg, prod_x_next, prod_y_reg, prod_y_next;
    logic signed [CW-1:0] px1_reg, py1_reg, px2_reg, py2_reg, px3_reg, py3_reg;
    logic signed [DW-1:0] sdist, dist_rnd;
    logic signed [KW-1:0] dc_reg, dc_next;
    logic                 in2_reg, in2_next, in3_reg, in4_reg;
    logic signed [RW-1:0] corr_x_reg, corr_x_next, corr_y_reg, corr_y_next;
    logic signed [RW-1:0] rc_x, rc_y;
    logic signed [JW-1:0] proj_x_reg, proj_x_next, proj_y_reg, proj_y_next;

    // stage 1: normal times corner
    always_comb
    begin
        prod_x_next = PW'(nx) * PW'(px);
        prod_y_next = PW'(ny) * PW'(py);
    end

    // stage 2: signed distance, sign test, distance rounded to the grid
    always_comb
    begin
        sdist    = DW'(prod_x_reg) + DW'(prod_y_reg) - (DW'(offset) <<< FR);
        dist_rnd = sdist + DW'(hpbc_pkg::ROUND_HALF);
        dc_next  = KW'(dist_rnd >>> FR);
        in2_next = sdist[DW-1];
    end

    // stage 3: correction along the normal
    always_comb
    begin
        corr_x_next = RW'(nx) * RW'(dc_reg);
        corr_y_next = RW'(ny) * RW'(dc_reg);
    end

    // stage 4: projected corner, zero when outside
    always_comb
    begin
        rc_x = (corr_x_reg + RW'(hpbc_pkg::ROUND_HALF)) >>> FR;
        rc_y = (corr_y_reg + RW'(hpbc_pkg::ROUND_HALF)) >>> FR;
        if (in3_reg)
        begin
            proj_x_next = JW'(px3_reg) - JW'(rc_x);
            proj_y_next = JW'(py3_reg) - JW'(rc_y);
        end
        else
        begin
            proj_x_next = '0;
            proj_y_next = '0;
        end
    end

    // stage registers
    always_ff @(posedge clk)
    begin
        if (en.s1)
        begin
            prod_x_reg <= prod_x_next;
            prod_y_reg <= prod_y_next;
            px1_reg    <= px;
            py1_reg    <= py;
        end
        if (en.s2)
        begin
            dc_reg  <= dc_next;
            in2_reg <= in2_next;
            px2_reg <= px1_reg;
            py2_reg <= py1_reg;
        end
        if (en.s3)
        begin
            corr_x_reg <= corr_x_next;
            corr_y_reg <= corr_y_next;
            in3_reg    <= in2_reg;
            px3_reg    <= px2_reg;
            py3_reg    <= py2_reg;
        end
        if (en.s4)
        begin
            proj_x_reg <= proj_x_next;
            proj_y_reg <= proj_y_next;
            in4_reg    <= in3_reg;
        end
    end

    assign proj_x    = proj_x_reg;
    assign proj_y    = proj_y_reg;
    assign corner_in = in4_reg;

endmodule

FILE: rtl/core/hpbc_mean.sv
module hpbc_mean (
    input  logic                                 clk,
    input  hpbc_pkg::mean_en_t                   en,
    input  logic signed [hpbc_pkg::SUM_W-1:0]    sum,
    input  logic [hpbc_pkg::CNT_W-1:0]           count,
    output logic signed [hpbc_pkg::COORD_W-1:0]  mean
);

    localparam int TW = hpbc_pkg::T_W;
    localparam int UW = hpbc_pkg::U_W;
    localparam int CW = hpbc_pkg::COORD_W;
    localparam int NW = hpbc_pkg::CNT_W;
    localparam int SP = hpbc_pkg::U_SPLIT;
    localparam int HW = hpbc_pkg::UH_W;
    localparam int VW = hpbc_pkg::V_W;
    localparam int M1W = hpbc_pkg::M1_W;
    localparam int MPW = hpbc_pkg::M2P_W;
    localparam int M2W = hpbc_pkg::M2_W;
    localparam logic signed [TW-1:0] T_BIAS = TW'(hpbc_pkg::DIV3_BIAS);
    localparam logic signed [TW-1:0] T_MAX  = TW'(hpbc_pkg::DIV3_BIAS - 3);
    localparam logic signed [TW-1:0] T_MIN  = -TW'(hpbc_pkg::DIV3_BIAS);
    localparam logic signed [TW-1:0] Q_BIAS = TW'(hpbc_pkg::DIV3_BIAS / 3);

    logic signed [TW-1:0] s_ext, t, tc, half, quarter, q3;
    logic [UW-1:0]        u_reg, u_next;
    logic signed [CW-1:0] qo6_reg, qo6_next, qo7_reg;
    logic [NW-1:0]        cnt6_reg, cnt7_reg;
    logic [HW-1:0]        uh;
    logic [VW-1:0]        v;
    logic [MPW-1:0]       m2_full;
    logic [M1W-1:0]       m1_reg, m1_next;
    logic [M2W-1:0]       m2_reg, m2_next;

    // stage 6: clamp and bias for the divide by three, shifts for counts two and four
    always_comb
    begin
        s_ext   = TW'(sum);
        t       = s_ext + TW'(1);
        half    = (s_ext + TW'(1)) >>> 1;
        quarter = (s_ext + TW'(2)) >>> 2;
        if (t > T_MAX)
        begin
            tc = T_MAX;
        end
        else if (t < T_MIN)
        begin
            tc = T_MIN;
        end
        else
        begin
            tc = t;
        end
        u_next = UW'(tc + T_BIAS);
        case (count)
            3'd2:    qo6_next = hpbc_pkg::sat32(half);
            3'd4:    qo6_next = hpbc_pkg::sat32(quarter);
            default: qo6_next = hpbc_pkg::sat32(s_ext);
        endcase
    end

    // stage 7: high part by exact multiple, low part by reciprocal
    always_comb
    begin
        uh      = u_reg[UW-1:SP];
        v       = VW'(uh) + VW'(u_reg[SP-1:0]);
        m1_next = M1W'(uh) * M1W'(hpbc_pkg::HI_MUL);
        m2_full = MPW'(v) * MPW'(hpbc_pkg::LO_MUL);
        m2_next = m2_full[MPW-1:hpbc_pkg::RECIP_SHIFT];
    end

    // final: remove bias, saturate, select by count
    always_comb
    begin
        q3 = TW'(m1_reg) + TW'(m2_reg) - Q_BIAS;
        if (cnt7_reg == NW'(3))
        begin
            mean = hpbc_pkg::sat32(q3);
        end
        else
        begin
            mean = qo7_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en.s6)
        begin
            u_reg    <= u_next;
            qo6_reg  <= qo6_next;
            cnt6_reg <= count;
        end
        if (en.s7)
        begin
            m1_reg   <= m1_next;
            m2_reg   <= m2_next;
            qo7_reg  <= qo6_reg;
            cnt7_reg <= cnt6_reg;
        end
    end

endmodule

FILE: rtl/core/half_plane_box_contact.sv
// Tests the four corners of a 2D box against a half-plane given by a Q2.14 normal and a
// Q16.16 offset, and returns a hit flag, the number of corners inside, the plane normal and
// the rounded mean of the inside corners projected onto the boundary line. The block is an
// eight-stage pipeline (four per-corner stages, a sum stage, two stages of the mean unit and
// the output register) and takes one item every cycle while the output side keeps up. Each
// stage holds its item until the next one is free, so an output stall fills bubbles before
// it stops the input. The plane registers feed the corner lanes and the output stage; the
// user must write them over the APB port only while no item is in flight (not enforced).
module half_plane_box_contact (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  hpbc_pkg::in_t                 in_data,
    output logic                          out_valid,
    input  logic                          out_ready,
    output hpbc_pkg::out_t                out_data,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [hpbc_pkg::ADDR_W-1:0]   paddr,
    input  logic [hpbc_pkg::DATA_W-1:0]   pwdata,
    output logic [hpbc_pkg::DATA_W-1:0]   prdata,
    output logic                          pready
);

    localparam int STAGES = 8;
    localparam int CW = hpbc_pkg::COORD_W;
    localparam int NW = hpbc_pkg::NORM_W;
    localparam int JW = hpbc_pkg::PROJ_W;
    localparam int SW = hpbc_pkg::SUM_W;
    localparam int KW = hpbc_pkg::CNT_W;
    localparam int NC = hpbc_pkg::NUM_CORNERS;
    localparam int DW = hpbc_pkg::DATA_W;

    logic signed [NW-1:0] normal_x_reg, normal_y_reg;
    logic signed [CW-1:0] offset_reg;
    logic                 wr_en;

    logic [STAGES-1:0]    valid_reg, valid_next, en;
    hpbc_pkg::lane_en_t   lane_en;
    hpbc_pkg::mean_en_t   mean_en;

    logic signed [CW-1:0] corner_x [NC];
    logic signed [CW-1:0] corner_y [NC];
    logic signed [JW-1:0] lane_px  [NC];
    logic signed [JW-1:0] lane_py  [NC];
    logic [NC-1:0]        lane_in;

    logic signed [SW-1:0] sum_x_reg, sum_x_next, sum_y_reg, sum_y_next;
    logic [KW-1:0]        cnt5_reg, cnt5_next, cnt6_reg, cnt7_reg;
    logic signed [CW-1:0] mean_x, mean_y;
    hpbc_pkg::out_t       out_reg, out_next;

    // configuration port
    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            normal_x_reg <= '0;
            normal_y_reg <= hpbc_pkg::NORMAL_ONE;
            offset_reg   <= '0;
        end
        else if (wr_en)
        begin
            case (paddr[3:2])
                hpbc_pkg::REG_NORMAL_X: normal_x_reg <= pwdata[NW-1:0];
                hpbc_pkg::REG_NORMAL_Y: normal_y_reg <= pwdata[NW-1:0];
                hpbc_pkg::REG_OFFSET:   offset_reg   <= pwdata[CW-1:0];
                default:                ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            hpbc_pkg::REG_NORMAL_X: prdata = DW'(normal_x_reg);
            hpbc_pkg::REG_NORMAL_Y: prdata = DW'(normal_y_reg);
            hpbc_pkg::REG_OFFSET:   prdata = DW'(offset_reg);
            default:                prdata = '0;
        endcase
    end

    // stage advance: a stage moves when empty or when the next one moves
    always_comb
    begin
        en[STAGES-1] = !valid_reg[STAGES-1] || out_ready;
        for (int i = STAGES - 2; i >= 0; i--)
        begin
            en[i] = !valid_reg[i] || en[i+1];
        end
        valid_next[0] = en[0] ? in_valid : valid_reg[0];
        for (int i = 1; i < STAGES; i++)
        begin
            valid_next[i] = en[i] ? valid_reg[i-1] : valid_reg[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    assign in_ready  = en[0];
    assign out_valid = valid_reg[STAGES-1];

    assign lane_en.s1 = en[0];
    assign lane_en.s2 = en[1];
    assign lane_en.s3 = en[2];
    assign lane_en.s4 = en[3];
    assign mean_en.s6 = en[5];
    assign mean_en.s7 = en[6];

    // corner lanes
    always_comb
    begin
        corner_x[0] = in_data.corner0_x;
        corner_y[0] = in_data.corner0_y;
        corner_x[1] = in_data.corner1_x;
        corner_y[1] = in_data.corner1_y;
        corner_x[2] = in_data.corner2_x;
        corner_y[2] = in_data.corner2_y;
        corner_x[3] = in_data.corner3_x;
        corner_y[3] = in_data.corner3_y;
    end

    for (genvar k = 0; k < NC; k++)
    begin : g_lane
        hpbc_corner u_corner (
            .clk       (clk),
            .en        (lane_en),
            .px        (corner_x[k]),
            .py        (corner_y[k]),
            .nx        (normal_x_reg),
            .ny        (normal_y_reg),
            .offset    (offset_reg),
            .proj_x    (lane_px[k]),
            .proj_y    (lane_py[k]),
            .corner_in (lane_in[k])
        );
    end

    // stage 5: sum of projected inside corners and their count
    always_comb
    begin
        sum_x_next = '0;
        sum_y_next = '0;
        cnt5_next  = '0;
        for (int k = 0; k < NC; k++)
        begin
            sum_x_next = sum_x_next + SW'(lane_px[k]);
            sum_y_next = sum_y_next + SW'(lane_py[k]);
            cnt5_next  = cnt5_next + KW'(lane_in[k]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[4])
        begin
            sum_x_reg <= sum_x_next;
            sum_y_reg <= sum_y_next;
            cnt5_reg  <= cnt5_next;
        end
        if (en[5])
        begin
            cnt6_reg <= cnt5_reg;
        end
        if (en[6])
        begin
            cnt7_reg <= cnt6_reg;
        end
        if (en[7])
        begin
            out_reg <= out_next;
        end
    end

    // stages 6 and 7: rounded mean per axis
    hpbc_mean u_mean_x (
        .clk   (clk),
        .en    (mean_en),
        .sum   (sum_x_reg),
        .count (cnt5_reg),
        .mean  (mean_x)
    );

    hpbc_mean u_mean_y (
        .clk   (clk),
        .en    (mean_en),
        .sum   (sum_y_reg),
        .count (cnt5_reg),
        .mean  (mean_y)
    );

    // stage 8: result item, all zero without a hit
    always_comb
    begin
        out_next.hit          = (cnt7_reg != '0);
        out_next.inside_count = cnt7_reg;
        if (cnt7_reg != '0)
        begin
            out_next.contact_x        = mean_x;
            out_next.contact_y        = mean_y;
            out_next.contact_normal_x = normal_x_reg;
            out_next.contact_normal_y = normal_y_reg;
        end
        else
        begin
            out_next.contact_x        = '0;
            out_next.contact_y        = '0;
            out_next.contact_normal_x = '0;
            out_next.contact_normal_y = '0;
        end
    end

    assign out_data = out_reg;

    // checks
    a_no_hit_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.hit |-> out_data.contact_x == '0 && out_data.contact_y == '0
            && out_data.contact_normal_x == '0 && out_data.contact_normal_y == '0)
        else $error("no-hit item carries a non-zero contact");

    a_hit_count: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_data.hit == (out_data.inside_count != '0))
        else $error("hit flag disagrees with inside count");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_data.inside_count <= KW'(NC))
        else $error("inside count above corner count");

    a_hit_normal: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.hit |-> out_data.contact_normal_x == normal_x_reg
            && out_data.contact_normal_y == normal_y_reg)
        else $error("contact normal differs from plane normal");

endmodule

FILE: bench/contact_checker.sv
module contact_checker
    import hpbc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic              in_ready,
    input  in_t               in_data,
    input  logic              out_valid,
    input  logic              out_ready,
    input  out_t              out_data,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    input  logic              pready,
    output int                fails,
    output int                pending
);

    localparam longint NORMAL_SCALE = longint'(1) << NORM_FRAC;
    localparam longint COORD_MAX    = (longint'(1) << (COORD_W - 1)) - 1;
    localparam longint COORD_MIN    = -(longint'(1) << (COORD_W - 1));

    // own copy of the plane registers
    logic signed [NORM_W-1:0]  plane_nx;
    logic signed [NORM_W-1:0]  plane_ny;
    logic signed [COORD_W-1:0] plane_d;

    out_t expected_contacts[$];
    int   mismatch_count = 0;
    int   awaiting = 0;
    int   result_index = 0;

    assign fails   = mismatch_count;
    assign pending = awaiting;

    function automatic longint floor_div(longint a, longint b);
        longint q;
        q = a / b;
        if ((a % b) != 0 && a < 0)
        begin
            q = q - 1;
        end
        return q;
    endfunction

    // a / b rounded half up, b positive
    function automatic longint round_half_up(longint a, longint b);
        return floor_div(2 * a + b, 2 * b);
    endfunction

    function automatic logic signed [COORD_W-1:0] clamp_coord(longint v);
        if (v > COORD_MAX)
        begin
            return COORD_MAX[COORD_W-1:0];
        end
        if (v < COORD_MIN)
        begin
            return COORD_MIN[COORD_W-1:0];
        end
        return v[COORD_W-1:0];
    endfunction

    // contact of one box against the current plane
    function automatic out_t predict_contact(in_t box);
        longint px [NUM_CORNERS];
        longint py [NUM_CORNERS];
        longint nx;
        longint ny;
        longint sdist;
        longint dc;
        longint sum_x;
        longint sum_y;
        longint count;
        out_t   r;
        px[0] = box.corner0_x;
        py[0] = box.corner0_y;
        px[1] = box.corner1_x;
        py[1] = box.corner1_y;
        px[2] = box.corner2_x;
        py[2] = box.corner2_y;
        px[3] = box.corner3_x;
        py[3] = box.corner3_y;
        nx = plane_nx;
        ny = plane_ny;
        sum_x = 0;
        sum_y = 0;
        count = 0;
        for (int k = 0; k < NUM_CORNERS; k++)
        begin
            sdist = nx * px[k] + ny * py[k] - longint'(plane_d) * NORMAL_SCALE;
            // a corner on the line is outside
            if (sdist < 0)
            begin
                dc = round_half_up(sdist, NORMAL_SCALE);
                sum_x += px[k] - round_half_up(nx * dc, NORMAL_SCALE);
                sum_y += py[k] - round_half_up(ny * dc, NORMAL_SCALE);
                count++;
            end
        end
        r = '0;
        if (count > 0)
        begin
            r.hit              = 1'b1;
            r.contact_x        = clamp_coord(round_half_up(sum_x, count));
            r.contact_y        = clamp_coord(round_half_up(sum_y, count));
            r.contact_normal_x = plane_nx;
            r.contact_normal_y = plane_ny;
            r.inside_count     = count[CNT_W-1:0];
        end
        return r;
    endfunction

    task automatic report_mismatch(string field, longint got, longint want);
        if (mismatch_count < 50)
        begin
            $display("result %0d: %s is %0d, predicted %0d", result_index, field, got, want);
        end
        mismatch_count++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        out_t want;
        if (!rst_n)
        begin
            plane_nx = '0;
            plane_ny = NORMAL_ONE;
            plane_d  = '0;
            expected_contacts.delete();
            awaiting = 0;
        end
        else
        begin
            // register writes, unknown indexes dropped
            if (psel && penable && pwrite && pready)
            begin
                case (paddr[3:2])
                    REG_NORMAL_X: plane_nx = pwdata[NORM_W-1:0];
                    REG_NORMAL_Y: plane_ny = pwdata[NORM_W-1:0];
                    REG_OFFSET:   plane_d  = pwdata[COORD_W-1:0];
                    default: ;
                endcase
            end

            // compare each result item with the oldest prediction
            if (out_valid && out_ready)
            begin
                if (expected_contacts.size() == 0)
                begin
                    report_mismatch("unexpected item", 1, 0);
                end
                else
                begin
                    want = expected_contacts.pop_front();
                    if (out_data.hit !== want.hit)
                    begin
                        report_mismatch("hit", out_data.hit, want.hit);
                    end
                    if (out_data.contact_x !== want.contact_x)
                    begin
                        report_mismatch("contact_x", out_data.contact_x, want.contact_x);
                    end
                    if (out_data.contact_y !== want.contact_y)
                    begin
                        report_mismatch("contact_y", out_data.contact_y, want.contact_y);
                    end
                    if (out_data.contact_normal_x !== want.contact_normal_x)
                    begin
                        report_mismatch("contact_normal_x", out_data.contact_normal_x,
                                        want.contact_normal_x);
                    end
                    if (out_data.contact_normal_y !== want.contact_normal_y)
                    begin
                        report_mismatch("contact_normal_y", out_data.contact_normal_y,
                                        want.contact_normal_y);
                    end
                    if (out_data.inside_count !== want.inside_count)
                    begin
                        report_mismatch("inside_count", out_data.inside_count,
                                        want.inside_count);
                    end
                end
                result_index++;
            end

            // predict for each accepted box
            if (in_valid && in_ready)
            begin
                expected_contacts.insert(expected_contacts.size(), predict_contact(in_data));
            end
            awaiting = expected_contacts.size();
        end
    end

endmodule

FILE: bench/testbench.sv
module testbench;
    import hpbc_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int LONG_HOLD   = 300;
    localparam int TAIL_CYCLES = 24;
    localparam int PHASES      = 8;
    localparam int PHASE_ITEMS = 192;

    localparam logic [1:0] REG_SPARE = 2'd3;

    typedef enum int { RX_ALWAYS, RX_RANDOM, RX_PATTERN } rx_mode_t;
    typedef enum int { BOX_RAW, BOX_ROTATED, BOX_GRAZING, BOX_EXTREME } box_kind_t;

    logic              clk;
    logic              rst_n;
    logic              in_valid;
    logic              in_ready;
    in_t               in_data;
    logic              out_valid;
    logic              out_ready;
    out_t              out_data;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    int fails;
    int pending;
    int cycle_count = 0;

    // plane as last written, for shaping boxes near the line
    int       cur_nx = 0;
    int       cur_ny = 16384;
    int       cur_d  = 0;
    rx_mode_t rx_mode = RX_ALWAYS;
    int       gap_max = 0;
    int       burst_left = 0;
    logic     hold_req = 1'b0;

    half_plane_box_contact dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    contact_checker u_checker (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .pready    (pready),
        .fails     (fails),
        .pending   (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // result side: long hold on request, otherwise the current stall mode
    initial
    begin
        int          hold_left;
        logic [15:0] stall_pat;
        int          pat_pos;
        hold_left = 0;
        stall_pat = 16'hffff;
        pat_pos   = 0;
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                hold_req  = 1'b0;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else
            begin
                case (rx_mode)
                    RX_RANDOM:  out_ready <= ($urandom_range(0, 9) > 2);
                    RX_PATTERN:
                    begin
                        out_ready <= stall_pat[pat_pos];
                        pat_pos++;
                        if (pat_pos == 16)
                        begin
                            pat_pos   = 0;
                            stall_pat = 16'($urandom) | 16'h8001;
                        end
                    end
                    default:    out_ready <= 1'b1;
                endcase
            end
        end
    end

    function automatic in_t make_corners(longint x0, longint y0, longint x1, longint y1,
                                         longint x2, longint y2, longint x3, longint y3);
        in_t r;
        r.corner0_x = 32'(x0);
        r.corner0_y = 32'(y0);
        r.corner1_x = 32'(x1);
        r.corner1_y = 32'(y1);
        r.corner2_x = 32'(x2);
        r.corner2_y = 32'(y2);
        r.corner3_x = 32'(x3);
        r.corner3_y = 32'(y3);
        return r;
    endfunction

    // signed random of up to max_bits bits, zero fairly often
    function automatic longint jitter(int max_bits);
        longint m;
        m = longint'($urandom) & ((longint'(1) << $urandom_range(0, max_bits)) - 1);
        if ($urandom_range(0, 1) == 1)
        begin
            m = -m;
        end
        return m;
    endfunction

    function automatic longint edge_value();
        case ($urandom_range(0, 5))
            0: return -(longint'(1) << 31);
            1: return 2147483647;
            2: return 0;
            3: return -1;
            4: return 1;
            default: return longint'(int'($urandom));
        endcase
    endfunction

    // random box of the given kind; rotated and grazing boxes lie around the current plane
    function automatic in_t make_box(box_kind_t kind);
        longint qx;
        longint qy;
        longint cx;
        longint cy;
        longint a;
        longint b;
        longint ux;
        longint uy;
        longint ex;
        longint ey;
        longint fx;
        longint fy;
        qx = longint'(cur_d) * cur_nx / 16384;
        qy = longint'(cur_d) * cur_ny / 16384;
        case (kind)
            BOX_ROTATED:
            begin
                cx = qx + jitter(26);
                cy = qy + jitter(26);
                a  = jitter(28);
                b  = jitter(28);
                ux = longint'($urandom_range(0, 32768)) - 16384;
                uy = longint'($urandom_range(0, 32768)) - 16384;
                ex = a * ux / 16384;
                ey = a * uy / 16384;
                fx = -b * uy / 16384;
                fy = b * ux / 16384;
                return make_corners(cx + ex + fx, cy + ey + fy, cx + ex - fx, cy + ey - fy,
                                    cx - ex - fx, cy - ey - fy, cx - ex + fx, cy - ey + fy);
            end
            BOX_GRAZING:
                return make_corners(qx + jitter(6), qy + jitter(6), qx + jitter(6),
                                    qy + jitter(6), qx + jitter(6), qy + jitter(6),
                                    qx + jitter(6), qy + jitter(6));
            BOX_EXTREME:
                return make_corners(edge_value(), edge_value(), edge_value(), edge_value(),
                                    edge_value(), edge_value(), edge_value(), edge_value());
            default:
                return make_corners($urandom, $urandom, $urandom, $urandom,
                                    $urandom, $urandom, $urandom, $urandom);
        endcase
    endfunction

    task automatic idle(int cycles);
        repeat (cycles)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
        end
    endtask

    // offer one item in bursts with random gaps, wait until taken
    task automatic offer(in_t box);
        int gap;
        if (burst_left == 0)
        begin
            gap        = $urandom_range(0, gap_max);
            burst_left = $urandom_range(1, 24);
            if (gap > 0)
            begin
                idle(gap);
            end
        end
        burst_left--;
        @(negedge clk);
        in_valid <= 1'b1;
        in_data  <= box;
        do
        begin
            @(posedge clk);
        end
        while (!in_ready);
    endtask

    task automatic reg_write(logic [1:0] index, logic [DATA_W-1:0] value);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {index, 2'b00};
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        do
        begin
            @(posedge clk);
        end
        while (!pready);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic set_plane(int nx, int ny, int d);
        reg_write(REG_NORMAL_X, 32'(nx));
        reg_write(REG_NORMAL_Y, 32'(ny));
        reg_write(REG_OFFSET, 32'(d));
        cur_nx = nx;
        cur_ny = ny;
        cur_d  = d;
    endtask

    task automatic drain();
        while (pending != 0)
        begin
            @(negedge clk);
        end
    endtask

    initial
    begin
        longint lo;
        longint hi;
        int     pick;
        int     nx;
        int     ny;
        lo = -(longint'(1) << 31);
        hi = 2147483647;
        rst_n    = 1'b0;
        in_valid = 1'b0;
        in_data  = '0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed boxes against the reset plane, y = 0 with normal +y
        rx_mode = RX_RANDOM;
        gap_max = 2;
        offer(make_corners(0, 1, 5, 1, 5, 7, 0, 7));
        offer(make_corners(-3, 0, 9, 0, 2, 0, hi, 0));
        offer(make_corners(10, -1, 20, 0, 20, 5, 10, 5));
        offer(make_corners(0, -3, 1, -3, 1, 4, 0, 4));
        offer(make_corners(-1, -3, 0, -3, 0, 4, -1, 4));
        offer(make_corners(0, -1, 0, -2, 1, -3, 0, 2));
        offer(make_corners(0, -1, 1, -2, 1, -3, 0, 2));
        offer(make_corners(-1, -1, -1, -2, 0, -3, 0, 2));
        offer(make_corners(lo, lo, lo, lo, lo, lo, lo, lo));
        offer(make_corners(hi, lo, hi, lo, hi, lo, hi, lo));
        offer(make_corners(hi, hi, hi, hi, hi, hi, hi, hi));
        offer(make_corners(lo, lo, hi, lo, lo, lo, hi, lo));
        offer(make_corners(-1, -1, -1, -1, -1, -1, -1, -1));
        offer(make_corners(hi, lo, hi, lo, hi, lo, 0, hi));
        offer(make_corners(lo, -1, hi, -65536, 0, 65536, 1, -32768));
        idle(1);
        drain();

        for (int phase = 1; phase <= PHASES; phase++)
        begin
            // new plane and new pacing for each phase
            case (phase)
                1:
                begin
                    set_plane(16384, 0, 0);
                    rx_mode = RX_ALWAYS;
                    gap_max = 0;
                end
                2:
                begin
                    set_plane(11585, 11585, int'(jitter(30)));
                    rx_mode = RX_RANDOM;
                    gap_max = 2;
                    hold_req = 1'b1;
                end
                3:
                begin
                    set_plane(-16384, 0, 32'h7fffffff);
                    rx_mode = RX_PATTERN;
                    gap_max = 4;
                end
                4:
                begin
                    set_plane(0, -16384, 32'h80000000);
                    rx_mode = RX_RANDOM;
                    gap_max = 8;
                end
                5:
                begin
                    nx = int'($urandom_range(0, 32768)) - 16384;
                    ny = int'($sqrt(real'(16384 * 16384 - nx * nx)));
                    if ($urandom_range(0, 1) == 1)
                    begin
                        ny = -ny;
                    end
                    set_plane(nx, ny, int'($urandom));
                    rx_mode = RX_PATTERN;
                    gap_max = 3;
                end
                6:
                begin
                    set_plane(-32768, 32767, int'(jitter(30)));
                    rx_mode = RX_ALWAYS;
                    gap_max = 5;
                end
                7:
                begin
                    set_plane(int'($urandom_range(0, 65535)) - 32768,
                              int'($urandom_range(0, 65535)) - 32768, int'($urandom));
                    rx_mode = RX_RANDOM;
                    gap_max = 1;
                end
                default:
                begin
                    // zero normal: every corner inside for a positive offset
                    set_plane(0, 0, 5 << 16);
                    reg_write(REG_SPARE, $urandom);
                    rx_mode = RX_PATTERN;
                    gap_max = 2;
                end
            endcase

            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 15)
                begin
                    offer(make_box(BOX_RAW));
                end
                else if (pick < 60)
                begin
                    offer(make_box(BOX_ROTATED));
                end
                else if (pick < 80)
                begin
                    offer(make_box(BOX_GRAZING));
                end
                else
                begin
                    offer(make_box(BOX_EXTREME));
                end
            end
            idle(1);
            drain();
        end

        // let any stray result item show up
        rx_mode = RX_ALWAYS;
        repeat (TAIL_CYCLES) @(negedge clk);
        if (fails == 0 && pending == 0)
        begin
            $display("Simulation PASSED");
        end
        else
        begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
